// File: rtl/sse_pkg.sv
package sse_pkg;

   // store size and derived widths
   localparam int BUF_DEPTH = 64;
   localparam int ADDR_W    = $clog2(BUF_DEPTH);
   localparam int LEN_W     = 7;
   localparam int BIT_W     = 3;
   localparam int SLOT_W    = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 7;

   // event kinds
   localparam logic [1:0] KIND_CLOCK = 2'd0;
   localparam logic [1:0] KIND_CS    = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_EN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_EN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TX_LEN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_LEN = 3'd4;

   typedef struct packed {
      logic             phase;
      logic             tx_en;
      logic             rx_en;
      logic [LEN_W-1:0] tx_len;
      logic [LEN_W-1:0] rx_len;
      logic             tx_clr;
      logic             rx_clr;
   } cfg_type;

   // effective length, clipped to the store size
   function automatic logic [LEN_W-1:0] len_limit(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] lim;
      lim = (32'(len) < BUF_DEPTH) ? len : LEN_W'(BUF_DEPTH);
      return lim;
   endfunction

endpackage

// File: rtl/sse_csr.sv
module sse_csr
   import sse_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output cfg_type              cfg
);

   logic             wr;
   logic             phase_ff, phase_in;
   logic             tx_en_ff, tx_en_in;
   logic             rx_en_ff, rx_en_in;
   logic [LEN_W-1:0] tx_len_ff, tx_len_in;
   logic [LEN_W-1:0] rx_len_ff, rx_len_in;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid;

   always_comb begin
      phase_in  = phase_ff;
      tx_en_in  = tx_en_ff;
      rx_en_in  = rx_en_ff;
      tx_len_in = tx_len_ff;
      rx_len_in = rx_len_ff;
      if (wr) begin
         unique case (csr_index)
            CSR_PHASE:  phase_in  = csr_wdata[0];
            CSR_TX_EN:  tx_en_in  = csr_wdata[0];
            CSR_RX_EN:  rx_en_in  = csr_wdata[0];
            CSR_TX_LEN: tx_len_in = csr_wdata[LEN_W-1:0];
            CSR_RX_LEN: rx_len_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= 1'b0;
         tx_en_ff  <= 1'b0;
         rx_en_ff  <= 1'b0;
         tx_len_ff <= '0;
         rx_len_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         tx_en_ff  <= tx_en_in;
         rx_en_ff  <= rx_en_in;
         tx_len_ff <= tx_len_in;
         rx_len_ff <= rx_len_in;
      end
   end

   always_comb begin
      cfg.phase  = phase_ff;
      cfg.tx_en  = tx_en_ff;
      cfg.rx_en  = rx_en_ff;
      cfg.tx_len = tx_len_ff;
      cfg.rx_len = rx_len_ff;
      cfg.tx_clr = wr && (csr_index == CSR_TX_EN || csr_index == CSR_TX_LEN);
      cfg.rx_clr = wr && (csr_index == CSR_RX_EN || csr_index == CSR_RX_LEN);
   end

endmodule

// File: rtl/sse_rx_mem.sv
module sse_rx_mem
   import sse_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic              a_en,
   input  logic [ADDR_W-1:0] a_addr,
   output logic [7:0]        a_data,
   input  logic [ADDR_W-1:0] b_addr,
   output logic [7:0]        b_data
);

   logic [7:0]           mem [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] valid_ff;
   logic [7:0]           a_dat_ff;
   logic                 a_vld_ff;
   logic [7:0]           b_dat_ff;
   logic                 b_vld_ff;
   logic                 a_hit;
   logic                 b_hit;

   assign a_hit = we && (waddr == a_addr);
   assign b_hit = we && (waddr == b_addr);

   // data path, write-first on an address match
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (a_en) begin
         a_dat_ff <= a_hit ? wdata : mem[a_addr];
      end
      b_dat_ff <= b_hit ? wdata : mem[b_addr];
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (a_en) begin
            a_vld_ff <= a_hit || valid_ff[a_addr];
         end
         b_vld_ff <= b_hit || valid_ff[b_addr];
      end
   end

   assign a_data = a_vld_ff ? a_dat_ff : 8'd0;
   assign b_data = b_vld_ff ? b_dat_ff : 8'd0;

endmodule

// File: rtl/sse_tx_mem.sv
module sse_tx_mem
   import sse_pkg::*;
(
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [7:0]        wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [7:0]        rdata
);

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= (we && waddr == raddr) ? wdata : mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/spi_slave_shift_engine.sv
// spi slave shift engine, driven by synchronized pin-edge events
//
// request channel (req_*): one event per request: a clock edge, a chip-select
//   edge, a host write into the transmit store or a host read of the receive
//   store. accepted on a rising edge with req_valid high and req_stall low
// response channel (rsp_*): exactly one response per request, in order,
//   taken on a rising edge with rsp_valid high and rsp_stall low
// csr channel (csr_*): register writes, always ready; write only while idle
// latency: a request accepted at edge t shows its response after edge t+1
// throughput: one request per cycle; the input register keeps filling while
//   a finished response waits in the output register
// both stores are 64-byte arrays; each keeps a registered read of the byte at
//   the current shift position, refreshed every cycle with write forwarding,
//   so a shift is a single-cycle read-modify-write
// reset: all positions, registers and the receive store read back as zero at
//   once (per-entry valid bits, no clearing pass); transmit store is unknown
//   until written
// a stalled response holds the output register; the input register then
//   holds its request and req_stall rises until the response is taken
module spi_slave_shift_engine
   import sse_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic                 req_pin_level,
   input  logic                 req_mosi,
   input  logic [SLOT_W-1:0]    req_slot,
   input  logic [7:0]           req_host_byte,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_miso_out,
   output logic                 rsp_miso_updated,
   output logic [LEN_W-1:0]     rsp_received_count,
   output logic [7:0]           rsp_read_byte,
   output logic                 rsp_clock_active,
   // csr channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type cfg;

   // input register
   logic              s1_vld_ff, s1_vld_in;
   logic [1:0]        s1_kind_ff;
   logic              s1_level_ff;
   logic              s1_mosi_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [7:0]        s1_byte_ff;
   logic              req_accept;
   logic              fire;

   // engine state
   logic             clk_en_ff, clk_en_in, clk_en_nx;
   logic             miso_ff, miso_in, miso_nx;
   logic [BIT_W-1:0] tx_bit_ff, tx_bit_in, tx_bit_nx;
   logic [LEN_W-1:0] tx_byte_ff, tx_byte_in, tx_byte_nx;
   logic [BIT_W-1:0] rx_bit_ff, rx_bit_in, rx_bit_nx;
   logic [LEN_W-1:0] rx_byte_ff, rx_byte_in, rx_byte_nx;

   // store ports
   logic [7:0] rx_cur;
   logic [7:0] rx_host;
   logic [7:0] tx_cur;
   logic       rx_we;
   logic [7:0] rx_wdata;
   logic       tx_we;
   logic       slot_ok;

   // event decode
   logic is_clk;
   logic do_sample;
   logic do_drive;
   logic [7:0] rd_byte;

   // output register
   logic             rsp_vld_ff, rsp_vld_in;
   logic             rsp_miso_ff;
   logic             rsp_upd_ff;
   logic [LEN_W-1:0] rsp_cnt_ff;
   logic [7:0]       rsp_rd_ff;
   logic             rsp_act_ff;

   sse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // handshake: the request in the input register moves on whenever the
   // output register is empty or being emptied
   assign fire       = s1_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall  = s1_vld_ff && !fire;
   assign req_accept = req_valid && !req_stall;
   assign s1_vld_in  = req_accept || (s1_vld_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff  <= req_kind;
         s1_level_ff <= req_pin_level;
         s1_mosi_ff  <= req_mosi;
         s1_slot_ff  <= req_slot;
         s1_byte_ff  <= req_host_byte;
      end
   end

   assign slot_ok = 32'(s1_slot_ff) < BUF_DEPTH;

   // clock edges only count while chip select is low; the edge level against
   // the phase picks sample or drive
   assign is_clk    = fire && (s1_kind_ff == KIND_CLOCK) && clk_en_ff;
   assign do_sample = is_clk && (s1_level_ff != cfg.phase) && cfg.rx_en
                      && (rx_byte_ff < len_limit(cfg.rx_len));
   assign do_drive  = is_clk && (s1_level_ff == cfg.phase) && cfg.tx_en
                      && (tx_byte_ff < len_limit(cfg.tx_len));

   // receive: shift mosi into the current byte, msb first
   assign rx_we    = do_sample;
   assign rx_wdata = {rx_cur[6:0], s1_mosi_ff};
   assign tx_we    = fire && (s1_kind_ff == KIND_WRITE) && slot_ok;

   always_comb begin
      clk_en_nx  = clk_en_ff;
      miso_nx    = miso_ff;
      tx_bit_nx  = tx_bit_ff;
      tx_byte_nx = tx_byte_ff;
      rx_bit_nx  = rx_bit_ff;
      rx_byte_nx = rx_byte_ff;
      if (do_sample) begin
         rx_bit_nx = rx_bit_ff + 3'd1;
         if (rx_bit_ff == 3'd7) begin
            rx_byte_nx = rx_byte_ff + 7'd1;
         end
      end
      if (do_drive) begin
         // bit order msb first
         miso_nx   = tx_cur[~tx_bit_ff];
         tx_bit_nx = tx_bit_ff + 3'd1;
         if (tx_bit_ff == 3'd7) begin
            tx_byte_nx = tx_byte_ff + 7'd1;
         end
      end
      if (fire && s1_kind_ff == KIND_CS) begin
         if (s1_level_ff) begin
            // chip select released
            clk_en_nx  = 1'b0;
            tx_bit_nx  = '0;
            tx_byte_nx = '0;
         end else begin
            // chip select asserted
            clk_en_nx  = 1'b1;
            rx_bit_nx  = '0;
            rx_byte_nx = '0;
         end
      end
   end

   // register writes clear the matching positions
   always_comb begin
      clk_en_in  = clk_en_nx;
      miso_in    = miso_nx;
      tx_bit_in  = tx_bit_nx;
      tx_byte_in = tx_byte_nx;
      rx_bit_in  = rx_bit_nx;
      rx_byte_in = rx_byte_nx;
      if (cfg.tx_clr) begin
         tx_bit_in  = '0;
         tx_byte_in = '0;
      end
      if (cfg.rx_clr) begin
         rx_bit_in  = '0;
         rx_byte_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_en_ff  <= 1'b0;
         miso_ff    <= 1'b0;
         tx_bit_ff  <= '0;
         tx_byte_ff <= '0;
         rx_bit_ff  <= '0;
         rx_byte_ff <= '0;
      end else begin
         clk_en_ff  <= clk_en_in;
         miso_ff    <= miso_in;
         tx_bit_ff  <= tx_bit_in;
         tx_byte_ff <= tx_byte_in;
         rx_bit_ff  <= rx_bit_in;
         rx_byte_ff <= rx_byte_in;
      end
   end

   // port a serves host reads, fetched as the request enters; port b tracks
   // the byte at the next receive position
   sse_rx_mem u_rx_mem (
      .clock  (clock),
      .reset  (reset),
      .we     (rx_we),
      .waddr  (ADDR_W'(rx_byte_ff)),
      .wdata  (rx_wdata),
      .a_en   (req_accept),
      .a_addr (ADDR_W'(req_slot)),
      .a_data (rx_host),
      .b_addr (ADDR_W'(rx_byte_in)),
      .b_data (rx_cur)
   );

   // read side tracks the byte at the next transmit position
   sse_tx_mem u_tx_mem (
      .clock (clock),
      .we    (tx_we),
      .waddr (ADDR_W'(s1_slot_ff)),
      .wdata (s1_byte_ff),
      .raddr (ADDR_W'(tx_byte_in)),
      .rdata (tx_cur)
   );

   assign rd_byte = (s1_kind_ff == KIND_READ && slot_ok) ? rx_host : 8'd0;

   // output register
   assign rsp_vld_in = fire || (rsp_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_miso_ff <= miso_nx;
         rsp_upd_ff  <= do_drive;
         rsp_cnt_ff  <= rx_byte_nx;
         rsp_rd_ff   <= rd_byte;
         rsp_act_ff  <= clk_en_nx;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_miso_out       = rsp_miso_ff;
   assign rsp_miso_updated   = rsp_upd_ff;
   assign rsp_received_count = rsp_cnt_ff;
   assign rsp_read_byte      = rsp_rd_ff;
   assign rsp_clock_active   = rsp_act_ff;

endmodule

// File: dv/spi_slave_shift_engine_tb.sv
`timescale 1ns / 1ps

module spi_slave_shift_engine_tb;
   import sse_pkg::*;

   // unused register index, writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_EVENTS = 850;

   // one pin or host event as carried by a request
   typedef struct {
      logic [1:0]        kind;
      logic              level;
      logic              mosi;
      logic [SLOT_W-1:0] slot;
      logic [7:0]        host_byte;
   } spi_event_type;

   // pin and buffer status returned for every event
   typedef struct {
      logic             miso;
      logic             updated;
      logic [LEN_W-1:0] rx_count;
      logic [7:0]       rd;
      logic             active;
   } pin_status_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_kind = KIND_READ;
   logic                 req_pin_level = 1'b0;
   logic                 req_mosi = 1'b0;
   logic [SLOT_W-1:0]    req_slot = '0;
   logic [7:0]           req_host_byte = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_miso_out;
   logic                 rsp_miso_updated;
   logic [LEN_W-1:0]     rsp_received_count;
   logic [7:0]           rsp_read_byte;
   logic                 rsp_clock_active;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PHASE;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   spi_slave_shift_engine uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_pin_level      (req_pin_level),
      .req_mosi           (req_mosi),
      .req_slot           (req_slot),
      .req_host_byte      (req_host_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_miso_out       (rsp_miso_out),
      .rsp_miso_updated   (rsp_miso_updated),
      .rsp_received_count (rsp_received_count),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_clock_active   (rsp_clock_active),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // shadow copy of the engine: stores, shift positions, chip-select state
   logic [7:0]       tx_mem [BUF_DEPTH];
   logic [7:0]       rx_mem [BUF_DEPTH];
   int               tx_bit = 0, tx_byte = 0, rx_bit = 0, rx_byte = 0;
   bit               clk_en = 1'b0, miso_lvl = 1'b0;
   bit               cfg_phase = 1'b0, cfg_tx_en = 1'b0, cfg_rx_en = 1'b0;
   logic [LEN_W-1:0] cfg_tx_len = '0, cfg_rx_len = '0;

   spi_event_type  pending_events [$];
   pin_status_type expected_status [$];
   spi_event_type  cur_event;
   int             events_queued = 0;
   int             results_seen = 0;
   int             sent_count = 0;
   int             mismatch_count = 0;
   int             hold_left = 0;
   bit             hold_done = 1'b0;
   int             quiet_cycles = 0;

   // byte limit actually applied, never past the end of a store
   function automatic int clip_len(input logic [LEN_W-1:0] len);
      return (int'(len) < BUF_DEPTH) ? int'(len) : BUF_DEPTH;
   endfunction

   // advance the shadow engine by one event and queue the status it must report
   function automatic void track_event(input spi_event_type ev);
      pin_status_type st;
      st.updated = 1'b0;
      st.rd      = '0;
      unique case (ev.kind)
         KIND_CLOCK: begin
            if (clk_en) begin
               // sampling edge is the one whose new level differs from the phase
               if (ev.level != cfg_phase) begin
                  if (cfg_rx_en && rx_byte < clip_len(cfg_rx_len)) begin
                     rx_mem[ADDR_W'(rx_byte)] = {rx_mem[ADDR_W'(rx_byte)][6:0], ev.mosi};
                     rx_bit++;
                     if (rx_bit == 8) begin
                        rx_bit = 0;
                        rx_byte++;
                     end
                  end
               end else if (cfg_tx_en && tx_byte < clip_len(cfg_tx_len)) begin
                  miso_lvl   = tx_mem[ADDR_W'(tx_byte)][3'(7 - tx_bit)];
                  st.updated = 1'b1;
                  tx_bit++;
                  if (tx_bit == 8) begin
                     tx_bit = 0;
                     tx_byte++;
                  end
               end
            end
         end
         KIND_CS: begin
            if (ev.level) begin
               clk_en  = 1'b0;
               tx_bit  = 0;
               tx_byte = 0;
            end else begin
               clk_en  = 1'b1;
               rx_bit  = 0;
               rx_byte = 0;
            end
         end
         KIND_WRITE: tx_mem[ev.slot] = ev.host_byte;
         KIND_READ:  st.rd = rx_mem[ev.slot];
      endcase
      st.miso     = miso_lvl;
      st.rx_count = LEN_W'(rx_byte);
      st.active   = clk_en;
      expected_status.push_back(st);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t ns  mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // random idling, switched off inside a quiet window of the run
   function automatic bit pause_now();
      if (sent_count >= 250 && sent_count < 450) return 1'b0;
      return $urandom_range(0, 99) < 31;
   endfunction

   function automatic spi_event_type random_event(input logic [1:0] kind);
      spi_event_type ev;
      ev.kind      = kind;
      ev.level     = 1'($urandom_range(0, 1));
      ev.mosi      = 1'($urandom_range(0, 1));
      ev.slot      = SLOT_W'($urandom_range(0, BUF_DEPTH - 1));
      ev.host_byte = 8'($urandom_range(0, 255));
      return ev;
   endfunction

   function automatic void push_event(input spi_event_type ev);
      pending_events.push_back(ev);
      events_queued++;
   endfunction

   // chip-select fall, a train of alternating sck edges with sparse host
   // traffic mixed in, then optionally the chip-select rise
   function automatic void queue_transfer(input int n_edges, input bit close_cs);
      spi_event_type ev;
      bit            sck;
      sck = 1'($urandom_range(0, 1));
      ev = random_event(KIND_CS);
      ev.level = 1'b0;
      push_event(ev);
      for (int i = 0; i < n_edges; i++) begin
         if ($urandom_range(0, 19) == 0)
            push_event(random_event($urandom_range(0, 1) ? KIND_WRITE : KIND_READ));
         sck = ~sck;
         ev = random_event(KIND_CLOCK);
         ev.level = sck;
         push_event(ev);
      end
      if (close_cs) begin
         ev = random_event(KIND_CS);
         ev.level = 1'b1;
         push_event(ev);
      end
   endfunction

   // mostly short lengths so limits get hit; zero, full and oversize now and then
   function automatic logic [LEN_W-1:0] pick_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 20) return LEN_W'(BUF_DEPTH);
      if (roll < 25) return LEN_W'($urandom_range(BUF_DEPTH + 1, 127));
      return LEN_W'($urandom_range(1, 4));
   endfunction

   // register writes go through only while nothing is in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      unique case (idx)
         CSR_PHASE: cfg_phase = val[0];
         CSR_TX_EN: begin
            cfg_tx_en = val[0];
            tx_bit    = 0;
            tx_byte   = 0;
         end
         CSR_RX_EN: begin
            cfg_rx_en = val[0];
            rx_bit    = 0;
            rx_byte   = 0;
         end
         CSR_TX_LEN: begin
            cfg_tx_len = val;
            tx_bit     = 0;
            tx_byte    = 0;
         end
         CSR_RX_LEN: begin
            cfg_rx_len = val;
            rx_bit     = 0;
            rx_byte    = 0;
         end
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      wait (results_seen == events_queued);
   endtask

   // request driver: tracks each accepted request, then offers the next one
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            track_event(cur_event);
            sent_count <= sent_count + 1;
         end
         // a stalled request holds its payload
         if (!req_valid || !req_stall) begin
            if (pending_events.size() != 0 && !pause_now()) begin
               cur_event = pending_events.pop_front();
               req_valid     <= 1'b1;
               req_kind      <= cur_event.kind;
               req_pin_level <= cur_event.level;
               req_mosi      <= cur_event.mosi;
               req_slot      <= cur_event.slot;
               req_host_byte <= cur_event.host_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off once, while the sender still has a backlog,
   // so both pipeline registers fill and req_stall has to rise
   always @(posedge clock) begin : rsp_hold
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && sent_count >= 600 && pending_events.size() > 16) begin
         hold_left <= 150;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor: each taken response against the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      pin_status_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_status.size() == 0) begin
               report_mismatch("response with no request outstanding", 1, 0);
            end else begin
               want = expected_status.pop_front();
               if (rsp_miso_out !== want.miso)
                  report_mismatch("miso_out", rsp_miso_out, want.miso);
               if (rsp_miso_updated !== want.updated)
                  report_mismatch("miso_updated", rsp_miso_updated, want.updated);
               if (rsp_received_count !== want.rx_count)
                  report_mismatch("received_count", rsp_received_count, want.rx_count);
               if (rsp_read_byte !== want.rd)
                  report_mismatch("read_byte", rsp_read_byte, want.rd);
               if (rsp_clock_active !== want.active)
                  report_mismatch("clock_active", rsp_clock_active, want.active);
            end
         end
         rsp_stall <= (hold_left > 0) || pause_now();
      end
   end

   // watchdog: too long without any handshake on any channel
   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", quiet_cycles);
            $display("spi_slave_shift_engine regression: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      spi_event_type ev;
      int            directed_total;
      bit            all_regs;
      int            n_xfer;

      for (int i = 0; i < BUF_DEPTH; i++) rx_mem[ADDR_W'(i)] = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // load every transmit byte first so no shift ever reads an unwritten one
      for (int i = 0; i < BUF_DEPTH; i++) begin
         ev = random_event(KIND_WRITE);
         ev.slot = SLOT_W'(i);
         if (i == 0) ev.host_byte = 8'hFF;
         if (i == 1) ev.host_byte = 8'h00;
         if (i == BUF_DEPTH - 1) ev.host_byte = 8'hA5;
         push_event(ev);
      end

      // reset config: receive store reads zero, sck ignored while deselected,
      // repeated chip-select levels, sck with both buffers absent
      ev = random_event(KIND_READ);  ev.slot = 0;               push_event(ev);
      ev = random_event(KIND_READ);  ev.slot = SLOT_W'(BUF_DEPTH - 1); push_event(ev);
      ev = random_event(KIND_CLOCK); ev.level = 1'b1;           push_event(ev);
      ev = random_event(KIND_CLOCK); ev.level = 1'b0;           push_event(ev);
      ev = random_event(KIND_CS);    ev.level = 1'b1;           push_event(ev);
      ev = random_event(KIND_CS);    ev.level = 1'b1;           push_event(ev);
      ev = random_event(KIND_CS);    ev.level = 1'b0;           push_event(ev);
      ev = random_event(KIND_CS);    ev.level = 1'b0;           push_event(ev);
      ev = random_event(KIND_CLOCK); ev.level = 1'b1;           push_event(ev);
      ev = random_event(KIND_CLOCK); ev.level = 1'b0;           push_event(ev);
      ev = random_event(KIND_CS);    ev.level = 1'b1;           push_event(ev);

      // mode 0, one byte each way, run past the limit on both sides
      wait_idle();
      write_reg(CSR_PHASE, 7'd0);
      write_reg(CSR_TX_EN, 7'd1);
      write_reg(CSR_RX_EN, 7'd1);
      write_reg(CSR_TX_LEN, 7'd1);
      write_reg(CSR_RX_LEN, 7'd1);
      write_reg(CSR_SPARE, 7'h7F);
      queue_transfer(20, 1'b1);
      ev = random_event(KIND_READ); ev.slot = 0; push_event(ev);
      ev = random_event(KIND_READ); ev.slot = 1; push_event(ev);

      // mode 1, lengths at and beyond the store size, left selected
      wait_idle();
      write_reg(CSR_PHASE, 7'h7F);
      write_reg(CSR_TX_LEN, 7'd127);
      write_reg(CSR_RX_LEN, LEN_W'(BUF_DEPTH));
      queue_transfer(20, 1'b0);

      // zero lengths, then buffers absent with nonzero lengths
      wait_idle();
      write_reg(CSR_TX_LEN, 7'd0);
      write_reg(CSR_RX_LEN, 7'd0);
      queue_transfer(6, 1'b1);
      wait_idle();
      write_reg(CSR_TX_EN, 7'h7E);
      write_reg(CSR_RX_EN, 7'h40);
      write_reg(CSR_TX_LEN, 7'd2);
      write_reg(CSR_RX_LEN, 7'd2);
      queue_transfer(8, 1'b1);
      directed_total = events_queued;

      // random phases: fresh settings, several transfers, some noise;
      // a phase may end mid-transfer so the next writes clear live positions
      all_regs = 1'b1;
      while (events_queued < directed_total + RANDOM_EVENTS) begin
         wait_idle();
         if (all_regs || $urandom_range(0, 99) < 60)
            write_reg(CSR_PHASE, CSR_DAT_W'($urandom_range(0, 127)));
         if (all_regs || $urandom_range(0, 99) < 60)
            write_reg(CSR_TX_EN, {6'($urandom_range(0, 63)), 1'($urandom_range(0, 99) < 85)});
         if (all_regs || $urandom_range(0, 99) < 60)
            write_reg(CSR_RX_EN, {6'($urandom_range(0, 63)), 1'($urandom_range(0, 99) < 85)});
         if (all_regs || $urandom_range(0, 99) < 60)
            write_reg(CSR_TX_LEN, pick_len());
         if (all_regs || $urandom_range(0, 99) < 60)
            write_reg(CSR_RX_LEN, pick_len());
         all_regs = 1'b0;
         n_xfer = $urandom_range(2, 4);
         for (int t = 0; t < n_xfer; t++) begin
            if ($urandom_range(0, 7) == 0)
               repeat ($urandom_range(1, 4)) push_event(random_event(2'($urandom_range(0, 3))));
            queue_transfer(16 * $urandom_range(1, 4) + $urandom_range(0, 4),
                           (t != n_xfer - 1) || ($urandom_range(0, 99) < 70));
            repeat ($urandom_range(0, 3)) push_event(random_event(KIND_READ));
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (expected_status.size() != 0)
         report_mismatch("responses never returned", 0, expected_status.size());
      if (mismatch_count == 0)
         $display("spi_slave_shift_engine regression: pass");
      else
         $display("spi_slave_shift_engine regression: fail");
      $finish;
   end

endmodule
